[rtl/vstl_pkg.sv]
// ----------------------------------------------------------------------------
// vstl_pkg
// Types and constants shared by the vector scale-to-length pipeline.
// ----------------------------------------------------------------------------
package vstl_pkg;

  localparam int WORD_BITS = 32;
  localparam int LEN_BITS  = WORD_BITS - 1;
  localparam int PROD_BITS = 2 * WORD_BITS - 1;  // |c| * len
  localparam int SUM_BITS  = 2 * WORD_BITS;      // 3 * c^2 still fits

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PROD_BITS-1:0] prod_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] comp_x;
    logic signed [WORD_BITS-1:0] comp_y;
    logic signed [WORD_BITS-1:0] comp_z;
    logic        [LEN_BITS-1:0]  target_len;
  } in_req_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] out_x;
    logic signed [WORD_BITS-1:0] out_y;
    logic signed [WORD_BITS-1:0] out_z;
    logic                        was_zero;
    logic                        saturated;
  } out_res_t;

  // Square-root pipeline word: radicand shifts out two bits per stage.
  typedef struct packed {
    logic [SUM_BITS-1:0]  s;
    logic [WORD_BITS:0]   rem;
    word_t                root;
    prod_t [2:0]          prod;
    logic [2:0]           neg;
    logic [LEN_BITS-1:0]  len;
    logic                 zero;
  } sq_t;

  // One divider lane per component.
  typedef struct packed {
    word_t rem;
    word_t quo;
    word_t dlo;
    logic  ovf;
    logic  neg;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [2:0]     lane;
    word_t               root;
    logic [LEN_BITS-1:0] len;
    logic                zero;
  } div_t;

endpackage

[rtl/vstl_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// vstl_sqrt_stage
// One registered digit of a restoring integer square root.
// ----------------------------------------------------------------------------
module vstl_sqrt_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  vstl_pkg::sq_t d_i,
  output logic          vld_o,
  output vstl_pkg::sq_t d_o
);
  import vstl_pkg::*;

  logic [WORD_BITS+1:0] rcat;
  logic [WORD_BITS+1:0] trial;
  logic [WORD_BITS+1:0] diff;
  logic                 ge;
  sq_t                  d_nxt;
  logic                 vld_r;
  sq_t                  d_r;

  always_comb begin
    rcat  = {d_i.rem[WORD_BITS-1:0], d_i.s[SUM_BITS-1 -: 2]};
    trial = {d_i.root, 2'b01};
    ge    = (rcat >= trial);
    diff  = rcat - trial;
    d_nxt      = d_i;
    d_nxt.s    = {d_i.s[SUM_BITS-3:0], 2'b00};
    d_nxt.rem  = ge ? diff[WORD_BITS:0] : rcat[WORD_BITS:0];
    d_nxt.root = {d_i.root[WORD_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    d_r <= d_nxt;
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

[rtl/vstl_div_stage.sv]
// ----------------------------------------------------------------------------
// vstl_div_stage
// One registered quotient bit of a restoring divide, three lanes wide.
// ----------------------------------------------------------------------------
module vstl_div_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  vstl_pkg::div_t d_i,
  output logic           vld_o,
  output vstl_pkg::div_t d_o
);
  import vstl_pkg::*;

  logic [WORD_BITS:0] r2   [3];
  logic [WORD_BITS:0] diff [3];
  logic [2:0]         ge;
  div_t               d_nxt;
  logic               vld_r;
  div_t               d_r;

  always_comb begin
    d_nxt = d_i;
    for (int i = 0; i < 3; i++) begin
      r2[i]   = {d_i.lane[i].rem, d_i.lane[i].dlo[WORD_BITS-1]};
      ge[i]   = (r2[i] >= {1'b0, d_i.root});
      diff[i] = r2[i] - {1'b0, d_i.root};
      d_nxt.lane[i].rem = ge[i] ? diff[i][WORD_BITS-1:0] : r2[i][WORD_BITS-1:0];
      d_nxt.lane[i].quo = {d_i.lane[i].quo[WORD_BITS-2:0], ge[i]};
      d_nxt.lane[i].dlo = {d_i.lane[i].dlo[WORD_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    d_r <= d_nxt;
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

[rtl/vector_scale_to_length.sv]
// ----------------------------------------------------------------------------
// vector_scale_to_length
// Scales a signed Q16.16 3-D vector to a requested length.
// Order: magnitude, square, sum, square root, divider setup, divide, output.
// Throughput: one request per cycle; busy is always low, since every stage
// advances each cycle and the result strobe cannot be held off.
// Reset (rst_n low, synchronous) clears all stage valid bits and sets
// zero_policy to 0; payload registers are not reset.
// ----------------------------------------------------------------------------
module vector_scale_to_length (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  vstl_pkg::in_req_t  in_req,
  output logic               out_valid,
  output vstl_pkg::out_res_t out_res,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import vstl_pkg::*;

  localparam word_t POS_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t NEG_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Config register
  logic zero_policy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_policy_r <= 1'b0;
    end else if (cfg_we) begin
      zero_policy_r <= cfg_wdata;
    end
  end

  // Fully pipelined, never stalls
  assign busy = 1'b0;
  logic acc;
  assign acc = start & ~busy;

  // Stage 1: magnitudes and signs
  logic                v1_r;
  word_t               mag_r [3];
  logic [2:0]          neg1_r;
  logic [LEN_BITS-1:0] len1_r;
  word_t               comp  [3];

  assign comp[0] = in_req.comp_x;
  assign comp[1] = in_req.comp_y;
  assign comp[2] = in_req.comp_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= acc;
    end
    for (int i = 0; i < 3; i++) begin
      neg1_r[i] <= comp[i][WORD_BITS-1];
      // -(-2^(W-1)) is still right as an unsigned magnitude
      mag_r[i]  <= comp[i][WORD_BITS-1] ? (~comp[i] + word_t'(1)) : comp[i];
    end
    len1_r <= in_req.target_len;
  end

  // Stage 2: squares for the norm, |c| * len for the dividend
  logic                v2_r;
  logic [SUM_BITS-1:0] sqr_r  [3];
  prod_t [2:0]         prod2_r;
  logic [2:0]          neg2_r;
  logic [LEN_BITS-1:0] len2_r;
  logic                zero2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    for (int i = 0; i < 3; i++) begin
      sqr_r[i]   <= mag_r[i] * mag_r[i];
      prod2_r[i] <= mag_r[i] * len1_r;
    end
    neg2_r  <= neg1_r;
    len2_r  <= len1_r;
    zero2_r <= (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
  end

  // Stage 3: sum of squares (3 * 2^(2W-2) fits in 2W bits)
  logic v3_r;
  sq_t  sq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    sq3_r.s    <= sqr_r[0] + sqr_r[1] + sqr_r[2];
    sq3_r.rem  <= '0;
    sq3_r.root <= '0;
    sq3_r.prod <= prod2_r;
    sq3_r.neg  <= neg2_r;
    sq3_r.len  <= len2_r;
    sq3_r.zero <= zero2_r;
  end

  // Square root: one root bit per stage, WORD_BITS stages
  logic sq_v [WORD_BITS+1];
  sq_t  sq_d [WORD_BITS+1];

  assign sq_v[0] = v3_r;
  assign sq_d[0] = sq3_r;

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_sqrt
    vstl_sqrt_stage u_sqrt (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (sq_v[g]),
      .d_i   (sq_d[g]),
      .vld_o (sq_v[g+1]),
      .d_o   (sq_d[g+1])
    );
  end

  // Divider setup: the high half of the dividend is the first partial
  // remainder; if it already reaches the root the quotient overflows.
  logic v4_r;
  div_t dv4_r;
  sq_t  sq_end;
  assign sq_end = sq_d[WORD_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= sq_v[WORD_BITS];
    end
    for (int i = 0; i < 3; i++) begin
      dv4_r.lane[i].rem <= {1'b0, sq_end.prod[i][PROD_BITS-1:WORD_BITS]};
      dv4_r.lane[i].ovf <= ({1'b0, sq_end.prod[i][PROD_BITS-1:WORD_BITS]} >= sq_end.root);
      dv4_r.lane[i].dlo <= sq_end.prod[i][WORD_BITS-1:0];
      dv4_r.lane[i].quo <= '0;
      dv4_r.lane[i].neg <= sq_end.neg[i];
    end
    dv4_r.root <= sq_end.root;
    dv4_r.len  <= sq_end.len;
    dv4_r.zero <= sq_end.zero;
  end

  // Divide: one quotient bit per stage for all three components
  logic dv_v [WORD_BITS+1];
  div_t dv_d [WORD_BITS+1];

  assign dv_v[0] = v4_r;
  assign dv_d[0] = dv4_r;

  for (genvar g = 0; g < WORD_BITS; g++) begin : g_div
    vstl_div_stage u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .vld_i (dv_v[g]),
      .d_i   (dv_d[g]),
      .vld_o (dv_v[g+1]),
      .d_o   (dv_d[g+1])
    );
  end

  // Output stage: sign, saturation, zero-vector fallback
  div_t       dv_end;
  word_t      res   [3];
  logic [2:0] clip;
  out_res_t   res_nxt;
  logic       out_valid_r;
  out_res_t   out_res_r;

  assign dv_end = dv_d[WORD_BITS];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_end.lane[i].neg) begin
        clip[i] = dv_end.lane[i].ovf || (dv_end.lane[i].quo > NEG_MIN);
        res[i]  = clip[i] ? NEG_MIN : (~dv_end.lane[i].quo + word_t'(1));
      end else begin
        clip[i] = dv_end.lane[i].ovf || dv_end.lane[i].quo[WORD_BITS-1];
        res[i]  = clip[i] ? POS_MAX : dv_end.lane[i].quo;
      end
    end
    if (dv_end.zero) begin
      res_nxt.out_x     = zero_policy_r ? {1'b0, dv_end.len} : '0;
      res_nxt.out_y     = '0;
      res_nxt.out_z     = '0;
      res_nxt.was_zero  = 1'b1;
      res_nxt.saturated = 1'b0;
    end else begin
      res_nxt.out_x     = res[0];
      res_nxt.out_y     = res[1];
      res_nxt.out_z     = res[2];
      res_nxt.was_zero  = 1'b0;
      res_nxt.saturated = |clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v[WORD_BITS];
    end
    out_res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
